### rtl/core/modular_exponentiation_top_defines.svh
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MEXP_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("modular exponentiation assertion failed");
`define MEXP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modular exponentiation assertion failed");
`else
`define MEXP_ASSERT(name, clk, rst, prop)
`define MEXP_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

### rtl/core/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_REDUCE = 6'b000010,
      ST_STEP   = 6'b000100,
      ST_MULT   = 6'b001000,
      ST_SQUARE = 6'b010000,
      ST_DONE   = 6'b100000
   } mexp_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mexp_mul_status_type;

endpackage

`default_nettype wire

### rtl/core/mexp_modmul.sv
`default_nettype none

`include "modular_exponentiation_top_defines.svh"

module mexp_modmul
   import mexp_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OPERAND_WIDTH-1:0] op_a,
   input  logic [OPERAND_WIDTH-1:0] op_x,
   input  logic [OPERAND_WIDTH-1:0] op_m,
   output logic [OPERAND_WIDTH-1:0] product,
   output mexp_mul_status_type      status
);

   localparam int CntWidth = $clog2(OPERAND_WIDTH);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CntWidth-1:0]      cnt_ff, cnt_in;
   logic [OPERAND_WIDTH-1:0] r_ff, r_in;
   logic [OPERAND_WIDTH-1:0] x_ff, x_in;
   logic [OPERAND_WIDTH-1:0] a_ff, a_in;
   logic [OPERAND_WIDTH-1:0] m_ff, m_in;

   logic [OPERAND_WIDTH:0]   dbl;
   logic [OPERAND_WIDTH:0]   dbl_red;
   logic [OPERAND_WIDTH:0]   sum;
   logic [OPERAND_WIDTH:0]   sum_red;

   // One multiplier bit per cycle, most significant first: double, then add.
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum     = {1'b0, dbl_red[OPERAND_WIDTH-1:0]}
                + (x_ff[OPERAND_WIDTH-1] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      x_in    = x_ff;
      a_in    = a_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntWidth'(OPERAND_WIDTH - 1);
         r_in    = '0;
         x_in    = op_x;
         a_in    = op_a;
         m_in    = op_m;
      end else if (busy_ff) begin
         r_in   = sum_red[OPERAND_WIDTH-1:0];
         x_in   = {x_ff[OPERAND_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      x_ff   <= x_in;
      a_ff   <= a_in;
      m_ff   <= m_in;
   end

   assign product     = r_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `MEXP_ASSERT(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff))
   `MEXP_ASSERT(a_product_reduced, clock, reset, done_ff |-> (r_ff < m_ff))

endmodule

`default_nettype wire

### rtl/core/modular_exponentiation_top.sv
// Channel  Direction  tdata (lowest bit up)                 tuser
// req      in         base, exponent, modulus               none
// rsp      out        result                                modulus_error
//
// The bit-serial modular multiplier serves the base reduction, every squaring
// and every multiply.
// A zero exponent or a zero modulus is offered in the cycle after the transfer.
// Reset is synchronous and returns the sequencer to idle; req_tready is high
// only when idle, and a held result waits in its register for rsp_tready.
`default_nettype none

`include "modular_exponentiation_top_defines.svh"

module modular_exponentiation_top
   import mexp_pkg::*;
#(
   parameter int OPERAND_WIDTH  = 32,
   parameter int EXPONENT_WIDTH = 64
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   // base, exponent, modulus
   input  logic [((2*OPERAND_WIDTH+EXPONENT_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   // result
   output logic [((OPERAND_WIDTH+7)/8)*8-1:0]              rsp_tdata,
   // modulus_error
   output logic                                            rsp_tuser
);

   localparam int W       = OPERAND_WIDTH;
   localparam int E       = EXPONENT_WIDTH;
   localparam int RspBits = ((OPERAND_WIDTH + 7) / 8) * 8;

   mexp_state_type      state_ff, state_in;
   logic [E-1:0]        e_ff, e_in;
   logic [W-1:0]        acc_ff, acc_in;
   logic [W-1:0]        sq_ff, sq_in;
   logic [W-1:0]        m_ff, m_in;
   logic [W-1:0]        res_ff, res_in;
   logic                err_ff, err_in;

   logic [W-1:0]        req_base;
   logic [E-1:0]        req_exponent;
   logic [W-1:0]        req_modulus;

   logic                mul_start;
   logic [W-1:0]        mul_a;
   logic [W-1:0]        mul_x;
   logic [W-1:0]        mul_m;
   logic [W-1:0]        mul_p;
   mexp_mul_status_type mul_status;

   assign req_base     = req_tdata[W-1:0];
   assign req_exponent = req_tdata[W+E-1:W];
   assign req_modulus  = req_tdata[2*W+E-1:W+E];

   mexp_modmul #(
      .OPERAND_WIDTH(W)
   ) u_modmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_x   (mul_x),
      .op_m   (mul_m),
      .product(mul_p),
      .status (mul_status)
   );

   always_comb begin
      state_in  = state_ff;
      e_in      = e_ff;
      acc_in    = acc_ff;
      sq_in     = sq_ff;
      m_in      = m_ff;
      res_in    = res_ff;
      err_in    = err_ff;
      mul_start = 1'b0;
      mul_a     = sq_ff;
      mul_x     = acc_ff;
      mul_m     = m_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               e_in   = req_exponent;
               m_in   = req_modulus;
               acc_in = W'(1);
               if (req_exponent == '0) begin
                  res_in   = W'(1);
                  err_in   = 1'b0;
                  state_in = ST_DONE;
               end else if (req_modulus == '0) begin
                  res_in   = '0;
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  // The base is reduced by multiplying it with one.
                  mul_start = 1'b1;
                  mul_a     = W'(1);
                  mul_x     = req_base;
                  mul_m     = req_modulus;
                  state_in  = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_status.done) begin
               sq_in    = mul_p;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (e_ff == '0) begin
               res_in   = acc_ff;
               err_in   = 1'b0;
               state_in = ST_DONE;
            end else if (e_ff[0]) begin
               mul_start = 1'b1;
               state_in  = ST_MULT;
            end else begin
               mul_start = 1'b1;
               mul_x     = sq_ff;
               e_in      = {1'b0, e_ff[E-1:1]};
               state_in  = ST_SQUARE;
            end
         end
         ST_MULT: begin
            if (mul_status.done) begin
               acc_in   = mul_p;
               e_in     = {e_ff[E-1:1], 1'b0};
               state_in = ST_STEP;
            end
         end
         ST_SQUARE: begin
            if (mul_status.done) begin
               sq_in    = mul_p;
               state_in = ST_STEP;
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff   <= e_in;
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      m_ff   <= m_in;
      res_ff <= res_in;
      err_ff <= err_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata  = RspBits'(res_ff);
   assign rsp_tuser  = err_ff;

   `MEXP_ASSERT(a_no_overlap, clock, reset, rsp_tvalid |-> !req_tready)
   `MEXP_ASSERT(a_error_zero, clock, reset, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
   `MEXP_ASSERT(a_unit_busy_in_compute, clock, reset,
                mul_status.busy |-> (state_ff == ST_REDUCE || state_ff == ST_MULT ||
                                     state_ff == ST_SQUARE))
   `MEXP_ASSERT_NEXT(a_start_leaves_idle, clock, reset, mul_start, mul_status.busy)

endmodule

`default_nettype wire
